/* src/tmwu_pkg.sv */
package tmwu_pkg;

    localparam int LEN_W  = 10;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int BE_W   = 4;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] ADDR_STEP   = 32'd4;
    localparam logic [BE_W-1:0]   BE_ALL      = 4'hF;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_DATA,
        PH_ENDED
    } phase_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] byte_addr;
        logic [DATA_W-1:0] write_data;
        logic [BE_W-1:0]   byte_enable;
    } result_t;

    function automatic logic is_write_header(input logic [DATA_W-1:0] w);
        return (w[31] == 1'b0) && (w[30] == 1'b1) && (w[28:10] == 19'd0);
    endfunction

endpackage

/* src/tlp_memory_write_unpacker.sv */
// a result passes from the decoder into the queue and then into the output register before out_valid shows it
// throughput: one word per cycle while the queue is not full (in_stall low), set by the header/data decoder
// a queue of QUEUE_DEPTH results lets the decoder run on while the output stalls
// reset (rst_n low, asynchronous): parser waits for header word 0, queue and
// output are emptied, address_limit returns to 0x0010_0000
module tlp_memory_write_unpacker #(
    parameter int MAX_LENGTH  = 1023,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tmwu_pkg::DATA_W-1:0]   word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [tmwu_pkg::ADDR_W-1:0]   byte_addr,
    output logic [tmwu_pkg::DATA_W-1:0]   write_data,
    output logic [tmwu_pkg::BE_W-1:0]     byte_enable,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmwu_pkg::ADDR_W-1:0]   cfg_data
);

    logic              accept;
    logic              push;
    logic              full;
    logic              not_empty;
    logic              pop;
    tmwu_pkg::result_t front_item;
    tmwu_pkg::result_t head_item;
    tmwu_pkg::result_t out_item;

    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    tmwu_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (word),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (front_item)
    );

    tmwu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_item (head_item)
    );

    tmwu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head_item (head_item),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign kind        = out_item.kind;
    assign byte_addr   = out_item.byte_addr;
    assign write_data  = out_item.write_data;
    assign byte_enable = out_item.byte_enable;

endmodule

/* src/tmwu_front.sv */
module tmwu_front #(
    parameter int MAX_LENGTH = 1023
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [tmwu_pkg::DATA_W-1:0]           word,
    input  logic                                  cfg_write,
    input  logic [tmwu_pkg::ADDR_W-1:0]           cfg_data,
    output logic                                  push,
    output tmwu_pkg::result_t                     item
);

    localparam logic [tmwu_pkg::LEN_W-1:0] LEN_CAP = tmwu_pkg::LEN_W'(MAX_LENGTH);

    tmwu_pkg::phase_t                  phase_reg, phase_next;
    logic [tmwu_pkg::LEN_W-1:0]        words_left_reg, words_left_next;
    logic [tmwu_pkg::LEN_W-1:0]        packet_length_reg, packet_length_next;
    logic                              first_word_reg, first_word_next;
    logic [tmwu_pkg::ADDR_W-1:0]       run_address_reg, run_address_next;
    logic [tmwu_pkg::BE_W-1:0]         first_enable_reg, first_enable_next;
    logic [tmwu_pkg::BE_W-1:0]         last_enable_reg, last_enable_next;
    logic                              skip_packet_reg, skip_packet_next;
    logic [tmwu_pkg::ADDR_W-1:0]       address_limit_reg;
    logic [tmwu_pkg::LEN_W-1:0]        hdr_len;

    assign hdr_len = (word[tmwu_pkg::LEN_W-1:0] > LEN_CAP) ? LEN_CAP
                                                          : word[tmwu_pkg::LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tmwu_pkg::PH_HDR0;
            words_left_reg    <= '0;
            packet_length_reg <= '0;
            first_word_reg    <= 1'b0;
            run_address_reg   <= '0;
            first_enable_reg  <= '0;
            last_enable_reg   <= '0;
            skip_packet_reg   <= 1'b0;
            address_limit_reg <= tmwu_pkg::LIMIT_RESET;
        end
        else
        begin
            phase_reg         <= phase_next;
            words_left_reg    <= words_left_next;
            packet_length_reg <= packet_length_next;
            first_word_reg    <= first_word_next;
            run_address_reg   <= run_address_next;
            first_enable_reg  <= first_enable_next;
            last_enable_reg   <= last_enable_next;
            skip_packet_reg   <= skip_packet_next;
            if (cfg_write)
            begin
                address_limit_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        words_left_next    = words_left_reg;
        packet_length_next = packet_length_reg;
        first_word_next    = first_word_reg;
        run_address_next   = run_address_reg;
        first_enable_next  = first_enable_reg;
        last_enable_next   = last_enable_reg;
        skip_packet_next   = skip_packet_reg;
        push               = 1'b0;
        item.kind          = tmwu_pkg::KIND_WRITE;
        item.byte_addr     = '0;
        item.write_data    = '0;
        item.byte_enable   = '0;

        if (accept)
        begin
            case (phase_reg)
                tmwu_pkg::PH_HDR0:
                begin
                    if (tmwu_pkg::is_write_header(word))
                    begin
                        packet_length_next = hdr_len;
                        phase_next         = tmwu_pkg::PH_HDR1;
                    end
                    else
                    begin
                        push       = 1'b1;
                        item.kind  = tmwu_pkg::KIND_END;
                        phase_next = tmwu_pkg::PH_ENDED;
                    end
                end
                tmwu_pkg::PH_HDR1:
                begin
                    first_enable_next = word[3:0];
                    last_enable_next  = word[7:4];
                    phase_next        = tmwu_pkg::PH_HDR2;
                end
                tmwu_pkg::PH_HDR2:
                begin
                    run_address_next = word;
                    skip_packet_next = word > address_limit_reg;
                    words_left_next  = packet_length_reg;
                    first_word_next  = 1'b1;
                    phase_next       = (packet_length_reg == '0) ? tmwu_pkg::PH_HDR0
                                                                 : tmwu_pkg::PH_DATA;
                end
                tmwu_pkg::PH_DATA:
                begin
                    push            = !skip_packet_reg;
                    item.kind       = tmwu_pkg::KIND_WRITE;
                    item.byte_addr  = run_address_reg;
                    item.write_data = word;
                    if (first_word_reg)
                    begin
                        item.byte_enable = first_enable_reg;
                    end
                    else if (words_left_reg == tmwu_pkg::LEN_W'(1))
                    begin
                        item.byte_enable = last_enable_reg;
                    end
                    else
                    begin
                        item.byte_enable = tmwu_pkg::BE_ALL;
                    end
                    run_address_next = run_address_reg + tmwu_pkg::ADDR_STEP;
                    first_word_next  = 1'b0;
                    words_left_next  = words_left_reg - tmwu_pkg::LEN_W'(1);
                    if (words_left_reg == tmwu_pkg::LEN_W'(1))
                    begin
                        phase_next = tmwu_pkg::PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = tmwu_pkg::PH_ENDED;
                end
            endcase
        end
    end

endmodule

/* src/tmwu_queue.sv */
module tmwu_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tmwu_pkg::result_t push_item,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output tmwu_pkg::result_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    tmwu_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/tmwu_back.sv */
module tmwu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  tmwu_pkg::result_t head_item,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output tmwu_pkg::result_t out_item
);

    logic              valid_reg;
    tmwu_pkg::result_t item_reg;

    // refill the output register whenever it is empty or being taken
    assign pop       = not_empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !out_stall)
        begin
            valid_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
    end

endmodule

/* test/tlp_memory_write_unpacker_test.sv */
module tlp_memory_write_unpacker_test;
    timeunit 1ns;
    timeprecision 1ps;

    class write_command_tracker;
        tmwu_pkg::phase_t  parse_phase;
        logic [9:0]        packet_words;
        logic [9:0]        words_left;
        logic [9:0]        word_index;
        logic [31:0]       next_addr;
        logic [31:0]       limit;
        logic [3:0]        first_be;
        logic [3:0]        last_be;
        bit                skipping;
        tmwu_pkg::result_t due_writes[$];
        int                mismatches;

        function new();
            parse_phase  = tmwu_pkg::PH_HDR0;
            packet_words = '0;
            words_left   = '0;
            word_index   = '0;
            next_addr    = '0;
            limit        = tmwu_pkg::LIMIT_RESET;
            first_be     = '0;
            last_be      = '0;
            skipping     = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_limit(logic [31:0] value);
            limit = value;
        endfunction

        function int pending();
            return due_writes.size();
        endfunction

        function void take_word(logic [31:0] w);
            tmwu_pkg::result_t r;
            logic [3:0]        be;
            case (parse_phase)
                tmwu_pkg::PH_HDR0:
                begin
                    if (!w[31] && w[30] && w[28:10] == 19'd0)
                    begin
                        packet_words = w[9:0];
                        parse_phase  = tmwu_pkg::PH_HDR1;
                    end
                    else
                    begin
                        r.kind        = tmwu_pkg::KIND_END;
                        r.byte_addr   = '0;
                        r.write_data  = '0;
                        r.byte_enable = '0;
                        due_writes.push_back(r);
                        parse_phase = tmwu_pkg::PH_ENDED;
                    end
                end
                tmwu_pkg::PH_HDR1:
                begin
                    first_be    = w[3:0];
                    last_be     = w[7:4];
                    parse_phase = tmwu_pkg::PH_HDR2;
                end
                tmwu_pkg::PH_HDR2:
                begin
                    next_addr   = w;
                    skipping    = (w > limit);
                    words_left  = packet_words;
                    word_index  = '0;
                    parse_phase = (packet_words == 10'd0) ? tmwu_pkg::PH_HDR0
                                                          : tmwu_pkg::PH_DATA;
                end
                tmwu_pkg::PH_DATA:
                begin
                    if (word_index == 10'd0)
                        be = first_be;
                    else if (words_left == 10'd1)
                        be = last_be;
                    else
                        be = tmwu_pkg::BE_ALL;
                    if (!skipping)
                    begin
                        r.kind        = tmwu_pkg::KIND_WRITE;
                        r.byte_addr   = next_addr;
                        r.write_data  = w;
                        r.byte_enable = be;
                        due_writes.push_back(r);
                    end
                    next_addr  = next_addr + tmwu_pkg::ADDR_STEP;
                    word_index = word_index + 10'd1;
                    words_left = words_left - 10'd1;
                    if (words_left == 10'd0)
                        parse_phase = tmwu_pkg::PH_HDR0;
                end
                default:
                    parse_phase = tmwu_pkg::PH_ENDED;
            endcase
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void check_write(tmwu_pkg::result_t got);
            tmwu_pkg::result_t want;
            if (due_writes.size() == 0)
            begin
                complain($sformatf("unexpected result kind %0d addr %h data %h be %h",
                                   got.kind, got.byte_addr, got.write_data, got.byte_enable));
                return;
            end
            want = due_writes.pop_front();
            if (got.kind !== want.kind || got.byte_addr !== want.byte_addr ||
                got.write_data !== want.write_data || got.byte_enable !== want.byte_enable)
                complain($sformatf({"expected kind %0d addr %h data %h be %h, ",
                                    "got kind %0d addr %h data %h be %h"},
                                   want.kind, want.byte_addr, want.write_data, want.byte_enable,
                                   got.kind, got.byte_addr, got.write_data, got.byte_enable));
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [tmwu_pkg::DATA_W-1:0] word = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        kind;
    logic [tmwu_pkg::ADDR_W-1:0] byte_addr;
    logic [tmwu_pkg::DATA_W-1:0] write_data;
    logic [tmwu_pkg::BE_W-1:0]   byte_enable;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [tmwu_pkg::ADDR_W-1:0] cfg_data = '0;

    write_command_tracker tracker;
    int burst_left = 0;
    int words_sent = 0;
    int stall_mode = 0;
    int stall_left = 0;

    tlp_memory_write_unpacker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .word        (word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_addr   (byte_addr),
        .write_data  (write_data),
        .byte_enable (byte_enable),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // every accepted transaction is seen here, in one process
    always @(posedge clk)
    begin
        tmwu_pkg::result_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_limit(cfg_data);
            if (in_valid && !in_stall)
                tracker.take_word(word);
            if (out_valid && !out_stall)
            begin
                seen.kind        = kind;
                seen.byte_addr   = byte_addr;
                seen.write_data  = write_data;
                seen.byte_enable = byte_enable;
                tracker.check_write(seen);
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 150);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_word(input logic [31:0] w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                word <= $urandom;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        in_valid <= 1'b1;
        word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_packet(input logic [9:0] len, input logic [3:0] first_be,
                               input logic [3:0] last_be, input logic [31:0] addr,
                               input bit solid);
        logic [31:0] noise;
        noise = $urandom;
        send_word({2'b01, noise[29], 19'd0, len});
        send_word({noise[31:8], last_be, first_be});
        send_word(addr);
        for (int i = 0; i < int'(len); i++)
            send_word(solid ? (i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF) : $urandom);
    endtask

    function automatic logic [9:0] pick_length();
        int unsigned roll;
        logic [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            v = 0;
        else if (roll < 70)
            v = $urandom_range(1, 4);
        else if (roll < 90)
            v = $urandom_range(5, 16);
        else
            v = $urandom_range(17, 64);
        return v[9:0];
    endfunction

    function automatic logic [31:0] pick_address(input logic [31:0] lim);
        case ($urandom_range(0, 5))
            0:       return lim;
            1:       return lim + 32'd1 + $urandom_range(0, 255);
            2:       return lim - $urandom_range(0, 4096);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 64);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int count, input logic [31:0] lim);
        int stop_at;
        logic [31:0] pick;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom;
            send_packet(pick_length(), pick[3:0], pick[7:4], pick_address(lim), 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] limit_now;
        logic [31:0] bad;
        tracker = new();
        limit_now = tmwu_pkg::LIMIT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_packet(10'd1, 4'hA, 4'h5, 32'h0000_0000, 1'b1);
        send_packet(10'd2, 4'h0, 4'hF, tmwu_pkg::LIMIT_RESET, 1'b1);
        send_packet(10'd3, 4'h3, 4'hC, tmwu_pkg::LIMIT_RESET + 32'd1, 1'b0);
        send_packet(10'd0, 4'hF, 4'hF, 32'h0000_1000, 1'b0);
        send_packet(10'd4, 4'hE, 4'h7, 32'h000F_FFF0, 1'b0);
        run_random(350, limit_now);
        wait_drained();

        limit_now = 32'hFFFF_FFFF;
        write_limit(limit_now);
        // address wraps through zero
        send_packet(10'd3, 4'h1, 4'h8, 32'hFFFF_FFF8, 1'b1);
        send_packet(10'd1023, 4'h6, 4'h9, $urandom, 1'b0);
        run_random(150, limit_now);
        wait_drained();

        limit_now = 32'h0000_0000;
        write_limit(limit_now);
        send_packet(10'd2, 4'h5, 4'hA, 32'h0000_0000, 1'b0);
        run_random(300, limit_now);
        wait_drained();

        limit_now = $urandom;
        write_limit(limit_now);
        run_random(300, limit_now);
        wait_drained();

        limit_now = $urandom_range(0, 32'h0002_0000);
        write_limit(limit_now);
        run_random(300, limit_now);

        // a non-write header ends the stream, later words are dropped
        case ($urandom_range(0, 2))
            0:       bad = $urandom | 32'h8000_0000;
            1:       bad = $urandom & 32'hBFFF_FFFF;
            default: bad = 32'h4000_0000 | ($urandom & 32'h2000_03FF)
                           | (32'h0000_0400 << $urandom_range(0, 18));
        endcase
        send_word(bad);
        repeat (20)
            send_word($urandom);
        wait_drained();
        repeat (20) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
